/* hw/rtl/pidpi_pkg.sv */
// Shared types, constants and helpers for the positional/incremental PID controller.
`default_nettype none

package pidpi_pkg;

	localparam int ErrW     = 16;
	localparam int GainW    = 16;
	localparam int LimW     = 31;
	localparam int DriveW   = 32;
	localparam int DeltaW   = 17;
	localparam int DDeltaW  = 18;
	localparam int T0W      = 25;
	localparam int T1W      = 40;
	localparam int T2W      = 26;
	localparam int SumW     = 42;
	localparam int AccW     = 43;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 31;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t RegMode     = 3'd0;
	localparam cfg_idx_t RegGainP    = 3'd1;
	localparam cfg_idx_t RegGainI    = 3'd2;
	localparam cfg_idx_t RegGainD    = 3'd3;
	localparam cfg_idx_t RegIntLimit = 3'd4;

	localparam logic [LimW-1:0] IntLimitReset = 31'h7FFF_FFFF;

	typedef enum logic {
		MODE_POS = 1'b0,
		MODE_INC = 1'b1
	} mode_t;

	// Multiplier operands handed from the state-update stage to the product stage.
	typedef struct packed {
		logic [DeltaW-1:0]  x0;
		logic [DriveW-1:0]  x1;
		logic [DDeltaW-1:0] x2;
		logic               sat;
	} pidpi_ops_t;

	// Load enables of the product and sum stages.
	typedef struct packed {
		logic ld3;
		logic ld4;
	} pidpi_adv_t;

	localparam logic signed [AccW-1:0] S32Max = 43'sd2147483647;
	localparam logic signed [AccW-1:0] S32Min = -43'sd2147483648;

	// Returns the overflow flag in the top bit and the clipped value below it.
	function automatic logic [DriveW:0] sat32(input logic signed [AccW-1:0] v);
		logic [DriveW:0] r;
		if (v > S32Max) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < S32Min) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DriveW-1:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/pidpi_terms.sv */
// Gain multiplier stage and term summing stage of the PID datapath.
`default_nettype none

module pidpi_terms (
	input  wire logic                             clk,
	input  wire pidpi_pkg::pidpi_adv_t            adv,
	input  wire logic [pidpi_pkg::GainW-1:0]      gain_p,
	input  wire logic [pidpi_pkg::GainW-1:0]      gain_i,
	input  wire logic [pidpi_pkg::GainW-1:0]      gain_d,
	input  wire pidpi_pkg::pidpi_ops_t            ops_s2,
	output logic signed [pidpi_pkg::SumW-1:0]     sum_s4,
	output logic                                  sat_s4
);
	import pidpi_pkg::*;

	logic signed [GainW+DeltaW-1:0]  prod0;
	logic signed [GainW+DriveW-1:0]  prod1;
	logic signed [GainW+DDeltaW-1:0] prod2;

	logic signed [T0W-1:0] t0_s3;
	logic signed [T1W-1:0] t1_s3;
	logic signed [T2W-1:0] t2_s3;
	logic                  sat_s3;

	assign prod0 = $signed(gain_p) * $signed(ops_s2.x0);
	assign prod1 = $signed(gain_i) * $signed(ops_s2.x1);
	assign prod2 = $signed(gain_d) * $signed(ops_s2.x2);

	// Dropping the low eight bits of a two's complement product rounds toward minus infinity.
	always_ff @(posedge clk) begin
		if (adv.ld3) begin
			t0_s3  <= $signed(prod0[GainW+DeltaW-1:8]);
			t1_s3  <= $signed(prod1[GainW+DriveW-1:8]);
			t2_s3  <= $signed(prod2[GainW+DDeltaW-1:8]);
			sat_s3 <= ops_s2.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld4) begin
			sum_s4 <= SumW'(t0_s3) + SumW'(t1_s3) + SumW'(t2_s3);
			sat_s4 <= sat_s3;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pid_positional_incremental.sv */
// Top level of the fixed-point PID controller with positional and incremental modes.
//
// One error sample enters per transaction on the s_axis channel (tdata[15:0], signed).
// Each sample yields exactly one transaction on m_axis: tdata holds the 32-bit signed
// drive and tuser the saturation flag. The block is a five-register pipeline: input,
// state update and operand select, gain products, term sum, and the output register
// that also closes the running-output accumulator.
// One sample is taken every cycle while the receiver keeps up. The per-sample state
// (integrator, previous error, previous delta) is updated in a single stage, which is
// what lets consecutive samples follow each other with no gap.
// When m_axis_tready is low, each stage keeps moving until it reaches a held stage,
// so up to five samples are buffered before s_axis_tready drops.
// The cfg port writes a register at every clock edge with cfg_we high; indexes beyond
// the register list are ignored. Write it only while the pipeline is empty.
// The asynchronous reset clears the pipeline, the controller state, mode and gains,
// and sets the integrator limit to its maximum.
`default_nettype none

module pid_positional_incremental (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pidpi_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [pidpi_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [15:0]                     s_axis_tdata,  // [15:0] error_in
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [31:0]                          m_axis_tdata,  // [31:0] drive
	output logic                                 m_axis_tuser   // [0] saturated
);
	import pidpi_pkg::*;

	mode_t             mode_q;
	logic [GainW-1:0]  gain_p_q;
	logic [GainW-1:0]  gain_i_q;
	logic [GainW-1:0]  gain_d_q;
	logic [LimW-1:0]   int_limit_q;

	logic signed [DriveW-1:0] integral_q;
	logic signed [ErrW-1:0]   prev_error_q;
	logic signed [DeltaW-1:0] prev_delta_q;
	logic signed [DriveW-1:0] running_q;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [ErrW-1:0]   e_s1;
	pidpi_ops_t               ops_s2;
	logic signed [SumW-1:0]   sum_s4;
	logic                     sat_s4;
	logic                     out_valid_q;
	logic [DriveW-1:0]        drive_q;
	logic                     sat_q;

	logic       ld1, ld2, ld3, ld4, ld_o;
	pidpi_adv_t adv;

	logic signed [DeltaW-1:0]  de;
	logic signed [DDeltaW-1:0] dde;
	logic signed [DriveW:0]    acc_raw;
	logic [DriveW:0]           acc_sat;
	logic signed [DriveW-1:0]  acc_c;
	logic signed [DriveW-1:0]  lim_pos;
	logic signed [DriveW-1:0]  lim_neg;
	pidpi_ops_t                ops_d;

	logic signed [AccW-1:0] fin_raw;
	logic [DriveW:0]        fin_sat;

	assign ld_o = !out_valid_q || m_axis_tready;
	assign ld4  = !v_s4 || ld_o;
	assign ld3  = !v_s3 || ld4;
	assign ld2  = !v_s2 || ld3;
	assign ld1  = !v_s1 || ld2;

	assign adv.ld3 = ld3;
	assign adv.ld4 = ld4;

	assign s_axis_tready = ld1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;
	assign m_axis_tuser  = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_POS;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			int_limit_q <= IntLimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegMode:     mode_q      <= mode_t'(cfg_data[0]);
				RegGainP:    gain_p_q    <= cfg_data[GainW-1:0];
				RegGainI:    gain_i_q    <= cfg_data[GainW-1:0];
				RegGainD:    gain_d_q    <= cfg_data[GainW-1:0];
				RegIntLimit: int_limit_q <= cfg_data[LimW-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1) v_s1 <= s_axis_tvalid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld_o) out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			e_s1 <= $signed(s_axis_tdata);
		end
	end

	always_comb begin
		de      = DeltaW'(e_s1) - DeltaW'(prev_error_q);
		dde     = DDeltaW'(de) - DDeltaW'(prev_delta_q);
		acc_raw = (DriveW+1)'(integral_q) + (DriveW+1)'(e_s1);
		acc_sat = sat32(AccW'(acc_raw));
		lim_pos = $signed({1'b0, int_limit_q});
		lim_neg = -lim_pos;
		acc_c   = $signed(acc_sat[DriveW-1:0]);
		if (acc_c > lim_pos) begin
			acc_c = lim_pos;
		end else if (acc_c < lim_neg) begin
			acc_c = lim_neg;
		end
		case (mode_q)
			MODE_POS: begin
				ops_d.x0  = DeltaW'(e_s1);
				ops_d.x1  = acc_c;
				ops_d.x2  = DDeltaW'(de);
				ops_d.sat = acc_sat[DriveW];
			end
			MODE_INC: begin
				ops_d.x0  = de;
				ops_d.x1  = DriveW'(e_s1);
				ops_d.x2  = dde;
				ops_d.sat = 1'b0;
			end
			default: begin
				ops_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			prev_error_q <= '0;
			prev_delta_q <= '0;
		end else if (ld2 && v_s1) begin
			prev_error_q <= e_s1;
			if (mode_q == MODE_POS) begin
				integral_q <= acc_c;
			end else begin
				prev_delta_q <= de;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			ops_s2 <= ops_d;
		end
	end

	pidpi_terms u_terms (
		.clk    (clk),
		.adv    (adv),
		.gain_p (gain_p_q),
		.gain_i (gain_i_q),
		.gain_d (gain_d_q),
		.ops_s2 (ops_s2),
		.sum_s4 (sum_s4),
		.sat_s4 (sat_s4)
	);

	always_comb begin
		if (mode_q == MODE_POS) begin
			fin_raw = AccW'(sum_s4);
		end else begin
			fin_raw = AccW'(running_q) + AccW'(sum_s4);
		end
		fin_sat = sat32(fin_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
		end else if (ld_o && v_s4) begin
			running_q <= $signed(fin_sat[DriveW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_o) begin
			drive_q <= fin_sat[DriveW-1:0];
			sat_q   <= fin_sat[DriveW] | sat_s4;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pidpi_checker.sv */
// Port-level assertions for the PID controller and the bind that attaches them.
`default_nettype none

module pidpi_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// A result transaction that is not taken stays offered with the same payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// A receiver that takes results never blocks the input side.
	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// With no result waiting, the pipeline has room for a new sample.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// Reset leaves no result on the output.
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result present after reset");

endmodule

bind pid_positional_incremental pidpi_checker u_pidpi_checker (.*);

`default_nettype wire

/* tb/sv/pid_drive_checker.sv */
// Checker that mirrors the PID controller's settings and state and compares every drive output.
module pid_drive_checker
	import pidpi_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  cfg_idx_t            cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [15:0]         s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [31:0]         m_tdata,
	input  logic                m_tuser,
	output int                  due_count,
	output int                  fail_count,
	output int                  match_total
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] drive;
		logic        sat;
	} drive_exp_t;

	drive_exp_t            due_q[$];
	mode_t                 run_mode;
	logic signed [15:0]    kp, ki, kd;
	logic [LimW-1:0]       int_lim;
	logic signed [31:0]    integ;
	logic signed [15:0]    last_err;
	logic signed [16:0]    last_delta;
	logic signed [31:0]    out_acc;
	int                    errs;
	int                    checked;

	function automatic longint clip32(input longint v, output bit hit);
		hit = 1'b0;
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic drive_exp_t next_drive(input logic signed [15:0] e);
		longint ev, kpv, kiv, kdv, de, acc, lim, drv, inc;
		bit h1, h2;
		drive_exp_t r;
		ev = longint'(e);
		kpv = longint'(kp);
		kiv = longint'(ki);
		kdv = longint'(kd);
		de = ev - longint'(last_err);
		h1 = 1'b0;
		h2 = 1'b0;
		if (run_mode == MODE_POS) begin
			lim = longint'(int_lim);
			acc = clip32(longint'(integ) + ev, h1);
			if (acc > lim) acc = lim;
			if (acc < -lim) acc = -lim;
			integ = acc[31:0];
			drv = clip32(((kpv * ev) >>> 8) + ((kiv * acc) >>> 8) + ((kdv * de) >>> 8), h2);
		end else begin
			inc = ((kpv * de) >>> 8) + ((kiv * ev) >>> 8)
				+ ((kdv * (de - longint'(last_delta))) >>> 8);
			drv = clip32(longint'(out_acc) + inc, h2);
			last_delta = de[16:0];
		end
		out_acc = drv[31:0];
		last_err = e;
		r.drive = drv[31:0];
		r.sat = h1 | h2;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_exp_t want;
		if (!arst_n) begin
			due_q.delete();
			run_mode = MODE_POS;
			kp = '0;
			ki = '0;
			kd = '0;
			int_lim = IntLimitReset;
			integ = '0;
			last_err = '0;
			last_delta = '0;
			out_acc = '0;
			errs = 0;
			checked = 0;
			due_count <= 0;
			fail_count <= 0;
			match_total <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegMode:     run_mode = mode_t'(cfg_data[0]);
					RegGainP:    kp = cfg_data[15:0];
					RegGainI:    ki = cfg_data[15:0];
					RegGainD:    kd = cfg_data[15:0];
					RegIntLimit: int_lim = cfg_data[LimW-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				due_q.push_back(next_drive($signed(s_tdata)));
			end
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					$error("output transaction with no sample waiting: drive %0d",
						$signed(m_tdata));
					errs++;
				end else begin
					want = due_q.pop_front();
					if (want.drive !== m_tdata) begin
						$error("drive mismatch: expected %0d, actual %0d",
							$signed(want.drive), $signed(m_tdata));
						errs++;
					end
					if (want.sat !== m_tuser) begin
						$error("saturated mismatch: expected %0b, actual %0b",
							want.sat, m_tuser);
						errs++;
					end
					checked++;
				end
			end
			due_count <= due_q.size();
			fail_count <= errs;
			match_total <= checked;
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the PID controller: clock, reset, stimulus, handshake pacing and verdict.
module tb;
	import pidpi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam cfg_idx_t RegSpareA = 3'd5;
	localparam cfg_idx_t RegSpareB = 3'd7;
	localparam int StallLimit = 2000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	cfg_idx_t            cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [15:0]         s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [31:0]         m_axis_tdata;
	logic                m_axis_tuser;

	int due_count, fail_count, match_total;
	int tx_idle_pct = 24;
	int rx_idle_pct = 24;
	int sent = 0;
	int cfg_sets = 0;
	int stall_cycles = 0;

	pid_positional_incremental dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	pid_drive_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tuser     (m_axis_tuser),
		.due_count   (due_count),
		.fail_count  (fail_count),
		.match_total (match_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= StallLimit) begin
				$display("tb: no transaction for %0d cycles, %0d outputs still due",
					StallLimit, due_count);
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	task automatic push_sample(input logic signed [15:0] e);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= e;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input mode_t m, input logic [15:0] p, input logic [15:0] i,
			input logic [15:0] d, input logic [LimW-1:0] lim);
		put_reg(RegMode, {30'($urandom), m});
		put_reg(RegGainP, {15'($urandom), p});
		put_reg(RegGainI, {15'($urandom), i});
		put_reg(RegGainD, {15'($urandom), d});
		put_reg(RegIntLimit, lim);
		cfg_sets++;
	endtask

	task automatic reconfigure(input mode_t m, input logic [15:0] p, input logic [15:0] i,
			input logic [15:0] d, input logic [LimW-1:0] lim);
		wait_drained();
		set_config(m, p, i, d, lim);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(3))
			0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			1:       return 16'($urandom_range(512)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [LimW-1:0] pick_limit();
		case ($urandom_range(3))
			0:       return '0;
			1:       return IntLimitReset;
			2:       return LimW'($urandom_range(100000));
			default: return LimW'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_error(input logic signed [15:0] prev);
		int v;
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: begin
				v = int'(prev) + int'($urandom_range(64)) - 32;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				return 16'(v);
			end
			4: return 16'(int'($urandom_range(2)) - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [15:0] pos_seq[$];
		logic signed [15:0] inc_seq[$];
		logic signed [15:0] e;

		pos_seq = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh7FFF, 16'sh7FFF,
			16'sh8000};
		inc_seq = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme gains with a small integrator clamp, then a zero clamp.
		reconfigure(MODE_POS, 16'h7FFF, 16'h8000, 16'h7FFF, 31'd1000);
		foreach (pos_seq[k]) push_sample(pos_seq[k]);
		reconfigure(MODE_POS, 16'h0100, 16'h7FFF, 16'h8000, '0);
		push_sample(16'sd5);
		push_sample(-16'sd5);
		push_sample(16'sh7FFF);

		// Switching to incremental carries the running output and the previous error.
		reconfigure(MODE_INC, 16'h8000, 16'h7FFF, 16'h8000, IntLimitReset);
		foreach (inc_seq[k]) push_sample(inc_seq[k]);

		// Back to positional; writes to unused indexes must change nothing.
		wait_drained();
		set_config(MODE_POS, 16'h0100, 16'h0100, 16'h0100, IntLimitReset);
		put_reg(RegSpareA, CfgDataW'($urandom));
		put_reg(RegSpareB, CfgDataW'($urandom));
		cfg_we <= 1'b0;
		push_sample(16'sd100);
		push_sample(-16'sd300);
		push_sample(16'sd7);

		// Random settings and samples; the middle phases run without any idling.
		e = '0;
		for (int ph = 0; ph < 8; ph++) begin
			tx_idle_pct = (ph == 3 || ph == 4) ? 0 : 24;
			rx_idle_pct = tx_idle_pct;
			reconfigure(mode_t'($urandom_range(1)), pick_gain(), pick_gain(), pick_gain(),
				pick_limit());
			for (int k = 0; k < 80; k++) begin
				if (k == 40 && $urandom_range(1)) wait_drained();
				e = pick_error(e);
				push_sample(e);
			end
		end

		// Zero the running output, ramp it in incremental mode until it pins at the top,
		// then bring it back down.
		tx_idle_pct = 24;
		rx_idle_pct = 24;
		reconfigure(MODE_POS, 16'h0000, 16'h0000, 16'h0000, IntLimitReset);
		push_sample(16'sd0);
		reconfigure(MODE_INC, 16'h0000, 16'h7FFF, 16'h0000, IntLimitReset);
		for (int k = 0; k < 560; k++) push_sample(16'($urandom_range(32000, 32767)));
		for (int k = 0; k < 40; k++) push_sample(16'sh8000 + 16'($urandom_range(2000)));

		// Empty the integrator with a zero clamp, then finish with random positional samples.
		reconfigure(MODE_POS, 16'h0000, 16'h0001, 16'h0000, '0);
		push_sample(16'sd1);
		reconfigure(MODE_POS, 16'h0000, 16'h0001, 16'h0000, IntLimitReset);
		for (int k = 0; k < 20; k++) push_sample(16'($urandom));

		wait_drained();
		repeat (12) @(posedge clk);
		$display("tb: %0d error samples over %0d controller settings, %0d outputs compared",
			sent, cfg_sets, match_total);
		$display("tb: both modes, gain and clamp extremes, running output saturation");
		if (fail_count == 0 && due_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

/* pid_positional_incremental.f */
hw/rtl/pidpi_pkg.sv
hw/rtl/pidpi_terms.sv
hw/rtl/pid_positional_incremental.sv
hw/rtl/pidpi_checker.sv
tb/sv/pid_drive_checker.sv
tb/sv/tb.sv
